// ===== src/sgne_pkg.sv =====
// Shared types and constants of the step gate note expander.
`timescale 1ns / 1ps

package sgne_pkg;

  localparam int unsigned PITCH_CLASSES = 12;
  localparam int unsigned NOTE_SPAN     = 128;
  localparam int unsigned MAX_LANES     = 16;
  localparam int unsigned LEVEL_BITS    = 7;
  localparam int unsigned NOTE_BITS     = 7;
  localparam int unsigned STEP_BITS     = MAX_LANES * LEVEL_BITS;
  localparam int unsigned DRUM_BITS     = MAX_LANES * NOTE_BITS;
  localparam int unsigned HALF_DRUMS    = DRUM_BITS / 2;
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned DIVIDEND_BITS = 2 * LEVEL_BITS;
  localparam int unsigned DIV_CNT_BITS  = $clog2(DIVIDEND_BITS);
  localparam logic [NOTE_BITS-1:0] FULL_VELOCITY = 7'd127;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PC_MASK   = 4'd0,
    CFG_PLAY_MODE = 4'd1,
    CFG_OCTAVE    = 4'd2,
    CFG_TRANSPOSE = 4'd3,
    CFG_VEL_BITS  = 4'd4,
    CFG_LANES     = 4'd5,
    CFG_DRUMS_LO  = 4'd6,
    CFG_DRUMS_HI  = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEL,
    ST_LANE,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [PITCH_CLASSES-1:0] pc_mask;
    logic                     rhythmic;
    logic signed [4:0]        octave;
    logic signed [7:0]        transpose;
    logic [2:0]               vel_bits;
    logic [4:0]               lane_count;
    logic [DRUM_BITS-1:0]     drums;
  } cfg_t;

  typedef struct packed {
    logic                     start;
    logic [DIVIDEND_BITS-1:0] dividend;
    logic [LEVEL_BITS-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [NOTE_BITS-1:0]  quotient;
  } div_rsp_t;

endpackage

// ===== src/sgne_cfg_regs.sv =====
// Configuration register file of the step gate note expander.
`timescale 1ns / 1ps

module sgne_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgne_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [sgne_pkg::HALF_DRUMS-1:0]     cfg_data_i,
  output sgne_pkg::cfg_t                      cfg_o
);

  sgne_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sgne_pkg::CFG_PC_MASK:   cfg_d.pc_mask    = cfg_data_i[sgne_pkg::PITCH_CLASSES-1:0];
        sgne_pkg::CFG_PLAY_MODE: cfg_d.rhythmic   = cfg_data_i[0];
        sgne_pkg::CFG_OCTAVE:    cfg_d.octave     = signed'(cfg_data_i[4:0]);
        sgne_pkg::CFG_TRANSPOSE: cfg_d.transpose  = signed'(cfg_data_i[7:0]);
        sgne_pkg::CFG_VEL_BITS:  cfg_d.vel_bits   = cfg_data_i[2:0];
        sgne_pkg::CFG_LANES:     cfg_d.lane_count = cfg_data_i[4:0];
        sgne_pkg::CFG_DRUMS_LO:
          cfg_d.drums[sgne_pkg::HALF_DRUMS-1:0] = cfg_data_i;
        sgne_pkg::CFG_DRUMS_HI:
          cfg_d.drums[sgne_pkg::DRUM_BITS-1:sgne_pkg::HALF_DRUMS] = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pc_mask    <= '1;
      cfg_q.rhythmic   <= 1'b0;
      cfg_q.octave     <= '0;
      cfg_q.transpose  <= '0;
      cfg_q.vel_bits   <= 3'd7;
      cfg_q.lane_count <= 5'd16;
      cfg_q.drums      <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/sgne_div.sv =====
// Serial restoring divider that scales rhythmic lane levels to velocities.
`timescale 1ns / 1ps

module sgne_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sgne_pkg::div_req_t  req_i,
  output sgne_pkg::div_rsp_t  rsp_o
);

  logic                                  busy_q, done_q;
  logic [sgne_pkg::DIV_CNT_BITS-1:0]     cnt_q;
  logic [sgne_pkg::DIVIDEND_BITS-1:0]    dvd_q;
  logic [sgne_pkg::LEVEL_BITS-1:0]       dvs_q, rem_q;
  logic [sgne_pkg::LEVEL_BITS:0]         rem_shift;
  logic                                  qbit;
  logic [sgne_pkg::LEVEL_BITS:0]         rem_sub;

  // The dividend register shifts out its top bit each step and takes the
  // new quotient bit at the bottom, so it ends up holding the quotient.
  assign rem_shift = {rem_q, dvd_q[sgne_pkg::DIVIDEND_BITS-1]};
  assign qbit      = (rem_shift >= {1'b0, dvs_q});
  assign rem_sub   = rem_shift - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= sgne_pkg::DIV_CNT_BITS'(sgne_pkg::DIVIDEND_BITS - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - sgne_pkg::DIV_CNT_BITS'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[sgne_pkg::DIVIDEND_BITS-2:0], qbit};
      rem_q <= qbit ? rem_sub[sgne_pkg::LEVEL_BITS-1:0]
                    : rem_shift[sgne_pkg::LEVEL_BITS-1:0];
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q[sgne_pkg::NOTE_BITS-1:0];

endmodule

// ===== src/step_gate_note_expander_core.sv =====
// Top level of the step gate note expander: sequencer, scan counters and output stage.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one step value (112 bits in two fields). The block
// then walks the step under a small sequencer and returns its note events on
// the output channel, one transfer per event, with last_of_step_o on the final
// one. A step with no events returns a single transfer with note_valid_o low.
// In melodic mode the sequencer checks one candidate note per cycle over all
// 128 notes, pausing while an event waits on a full output side. In rhythmic
// mode it visits the lanes in turn and runs the serial divider for each
// sounding lane to scale its level to a velocity. The input is not ready
// again until the last result of a step sits in the output register. When the
// receiver stalls, one event waits in the output register and one more in a
// hold stage; the scan pauses after that. Configuration writes go through a
// separate channel that is always ready and are meant for idle periods only.
// Reset returns the state, configuration and control registers to their
// defaults and empties both output stages.

module step_gate_note_expander_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [63:0]                         step_bits_low_i,
  input  logic [47:0]                         step_bits_high_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [6:0]                          note_number_o,
  output logic [6:0]                          note_velocity_o,
  output logic                                note_valid_o,
  output logic                                last_of_step_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sgne_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [sgne_pkg::HALF_DRUMS-1:0]     cfg_data_i
);

  localparam int unsigned NB = sgne_pkg::NOTE_BITS;
  localparam int unsigned LB = sgne_pkg::LEVEL_BITS;

  sgne_pkg::cfg_t     cfg;
  sgne_pkg::div_req_t div_req;
  sgne_pkg::div_rsp_t div_st;
  sgne_pkg::state_e   state_q, state_d;

  sgne_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sgne_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_st)
  );

  // Scan state.
  logic [NB-1:0]                    note_q;
  logic [3:0]                       pc_q;
  logic [NB:0]                      rank_q;
  logic [3:0]                       lane_q;
  logic [sgne_pkg::STEP_BITS-1:0]   shift_q;
  logic [31:0]                      mag_q;
  logic                             neg_q;
  logic signed [9:0]                base_q;
  logic [NB-1:0]                    cur_note_q;

  // Hold stage and output register.
  logic          pend_valid_q;
  logic [NB-1:0] pend_note_q, pend_vel_q;
  logic          out_valid_q;
  logic [NB-1:0] out_note_q, out_vel_q;
  logic          out_nv_q, out_last_q;

  // Control from the sequencer.
  logic          accept, adv_mel, adv_lane, ev_fire, fin_fire;
  logic [NB-1:0] ev_note, ev_vel;

  // Values derived from the step and configuration.
  logic [31:0]        raw;
  logic [3:0]         pc_count;
  logic signed [4:0]  k_s;
  logic signed [9:0]  base_d;
  logic signed [10:0] base_x, rank_x, bi;
  logic               bi_ok, mel_sel, mask_bit;
  logic signed [8:0]  mel_t, drum_t;
  logic [2:0]         width;
  logic [4:0]         lanes;
  logic [LB-1:0]      maxv, level;
  logic [NB-1:0]      drum_note;
  logic               last_lane, out_free, blocked;

  assign raw      = step_bits_low_i[31:0];
  assign pc_count = 4'($countones(cfg.pc_mask));
  assign k_s      = signed'({1'b0, pc_count});
  assign base_d   = 10'(cfg.octave) * 10'(k_s);

  assign mask_bit = cfg.pc_mask[pc_q];
  assign base_x   = 11'(base_q);
  assign rank_x   = signed'({3'b000, rank_q});
  assign bi       = neg_q ? (base_x - rank_x) : (rank_x - base_x);
  assign bi_ok    = !bi[10] && (bi[9:5] == '0);
  assign mel_sel  = mask_bit && bi_ok && mag_q[bi[4:0]];
  assign mel_t    = signed'({2'b00, note_q}) + 9'(cfg.transpose);

  assign width     = (cfg.vel_bits == '0) ? 3'd1 : cfg.vel_bits;
  assign lanes     = (cfg.lane_count == '0) ? 5'd1
                   : (cfg.lane_count > 5'(sgne_pkg::MAX_LANES)) ? 5'(sgne_pkg::MAX_LANES)
                   : cfg.lane_count;
  assign maxv      = {LB{1'b1}} >> (3'(LB) - width);
  assign level     = shift_q[LB-1:0] & maxv;
  assign drum_note = cfg.drums[lane_q*NB +: NB];
  assign drum_t    = signed'({2'b00, drum_note}) + 9'(cfg.transpose);
  assign last_lane = ({1'b0, lane_q} + 5'd1) == lanes;

  assign out_free = !out_valid_q || out_ready_i;
  assign blocked  = pend_valid_q && !out_free;

  always_comb begin
    state_d          = state_q;
    accept           = 1'b0;
    adv_mel          = 1'b0;
    adv_lane         = 1'b0;
    ev_fire          = 1'b0;
    fin_fire         = 1'b0;
    ev_note          = mel_t[NB-1:0];
    ev_vel           = sgne_pkg::FULL_VELOCITY;
    // Rounded scaling: (level * 127 + maxv / 2) / maxv.
    div_req.dividend = ({level, 7'b0} - {7'b0, level}) + {8'b0, maxv[LB-1:1]};
    div_req.divisor  = maxv;
    div_req.start    = 1'b0;
    in_ready_o       = 1'b0;
    unique case (state_q)
      sgne_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = cfg.rhythmic ? sgne_pkg::ST_LANE : sgne_pkg::ST_MEL;
        end
      end
      sgne_pkg::ST_MEL: begin
        if (!(mel_sel && !mel_t[8] && !mel_t[7] && blocked)) begin
          adv_mel = 1'b1;
          ev_fire = mel_sel && !mel_t[8] && !mel_t[7];
          if (note_q == NB'(sgne_pkg::NOTE_SPAN - 1)) begin
            state_d = sgne_pkg::ST_FIN;
          end
        end
      end
      sgne_pkg::ST_LANE: begin
        if ((level != '0) && !drum_t[8] && !drum_t[7]) begin
          div_req.start = 1'b1;
          state_d       = sgne_pkg::ST_DIV;
        end else begin
          adv_lane = 1'b1;
          if (last_lane) begin
            state_d = sgne_pkg::ST_FIN;
          end
        end
      end
      sgne_pkg::ST_DIV: begin
        ev_note = cur_note_q;
        ev_vel  = div_st.quotient;
        if (div_st.done && !blocked) begin
          ev_fire  = 1'b1;
          adv_lane = 1'b1;
          state_d  = last_lane ? sgne_pkg::ST_FIN : sgne_pkg::ST_LANE;
        end
      end
      sgne_pkg::ST_FIN: begin
        if (out_free) begin
          fin_fire = 1'b1;
          state_d  = sgne_pkg::ST_IDLE;
        end
      end
      default: state_d = sgne_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgne_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers of the output side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ev_fire) begin
        pend_valid_q <= 1'b1;
      end else if (fin_fire || accept) begin
        pend_valid_q <= 1'b0;
      end
      if ((ev_fire && pend_valid_q) || fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: scan counters, step copy, hold stage and output fields.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      note_q  <= '0;
      pc_q    <= '0;
      rank_q  <= '0;
      lane_q  <= '0;
      shift_q <= {step_bits_high_i, step_bits_low_i};
      neg_q   <= raw[31];
      mag_q   <= raw[31] ? (32'd0 - raw) : raw;
      base_q  <= base_d;
    end
    if (adv_mel) begin
      note_q <= note_q + NB'(1);
      pc_q   <= (pc_q == 4'(sgne_pkg::PITCH_CLASSES - 1)) ? 4'd0 : pc_q + 4'd1;
      rank_q <= rank_q + {{NB{1'b0}}, mask_bit};
    end
    if (adv_lane) begin
      lane_q  <= lane_q + 4'd1;
      shift_q <= shift_q >> width;
    end
    if (div_req.start) begin
      cur_note_q <= drum_t[NB-1:0];
    end
    if (ev_fire) begin
      pend_note_q <= ev_note;
      pend_vel_q  <= ev_vel;
    end
    if (ev_fire && pend_valid_q) begin
      out_note_q <= pend_note_q;
      out_vel_q  <= pend_vel_q;
      out_nv_q   <= 1'b1;
      out_last_q <= 1'b0;
    end else if (fin_fire) begin
      out_note_q <= pend_valid_q ? pend_note_q : '0;
      out_vel_q  <= pend_valid_q ? pend_vel_q : '0;
      out_nv_q   <= pend_valid_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign note_number_o   = out_note_q;
  assign note_velocity_o = out_vel_q;
  assign note_valid_o    = out_nv_q;
  assign last_of_step_o  = out_last_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sgne_pkg::ST_IDLE |-> !pend_valid_q)
    else $error("pending event left over while idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a step transfer");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !note_valid_o |->
      last_of_step_o && note_number_o == '0 && note_velocity_o == '0)
    else $error("empty-step result malformed");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sgne_pkg::ST_IDLE |-> !div_st.busy)
    else $error("divider busy while idle");

endmodule
